[sv/hue_gradient_pixel_color_assert.svh]
// Assertion macros for the hue gradient pixel color block.
// Expects signals named clk and arst_n in the including module.
`ifndef HUE_GRADIENT_PIXEL_COLOR_ASSERT_SVH
`define HUE_GRADIENT_PIXEL_COLOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define HGPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define HGPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);

`endif

[sv/hgpc_pkg.sv]
// Shared types and constants for the hue gradient pixel color block.
// No dependencies.
package hgpc_pkg;

	localparam int COORD_BITS = 12;
	localparam int REG_BITS   = COORD_BITS + 1;
	localparam int ADDR_BITS  = 3;
	localparam int DATA_BITS  = 32;

	// register index, taken from paddr[2]
	localparam logic REG_AREA_WIDTH  = 1'b0;
	localparam logic REG_AREA_HEIGHT = 1'b1;

	// how a fraction lane gets its value
	typedef enum logic [1:0] {
		SEL_DIV,
		SEL_ZERO,
		SEL_ONE
	} sel_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
	} req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rsp_t;

endpackage

[sv/hgpc_div_cell.sv]
// One registered step of a restoring divider: one quotient bit per cell.
// Standalone; chained by hue_gradient_pixel_color.
module hgpc_div_cell #(
	parameter int RW = 13,
	parameter int QW = 16
) (
	input  logic          clk,
	input  logic [RW-1:0] divisor,
	input  logic [RW-1:0] rem_in,
	input  logic [QW-1:0] quo_in,
	output logic [RW-1:0] rem_out,
	output logic [QW-1:0] quo_out
);

	logic [RW:0]   trial;
	logic          ge;
	logic [RW:0]   diff;
	logic [RW-1:0] rem_q;
	logic [QW-1:0] quo_q;

	// dividend bits leave the top of quo, quotient bits enter at the bottom
	always_comb begin
		trial = {rem_in, quo_in[QW-1]};
		ge    = trial >= {1'b0, divisor};
		diff  = ge ? (trial - {1'b0, divisor}) : trial;
	end

	always_ff @(posedge clk) begin
		rem_q <= diff[RW-1:0];
		quo_q <= {quo_in[QW-2:0], ge};
	end

	assign rem_out = rem_q;
	assign quo_out = quo_q;

endmodule

[sv/hue_gradient_pixel_color.sv]
// Top level: APB registers, divider cell chains and HSV-to-RGB output stages.
// Depends on hgpc_pkg, hgpc_div_cell and hue_gradient_pixel_color_assert.svh.
//
//   port group     | direction | handshake
//   ---------------+-----------+---------------------------------------
//   req            | in        | taken when start && !busy
//   rsp            | out       | one cycle, marked by done
//   apb            | in/out    | write when psel && penable && pwrite
//
// One request per cycle; busy is never raised. Each result passes through
// the input register, the COORD_BITS cells of the modulo chain, the
// FRAC_BITS cells of the divide chain and three output stages. Reset clears
// the valid line and loads width and height 256. The receiver cannot stall;
// nothing waits.
`include "hue_gradient_pixel_color_assert.svh"

module hue_gradient_pixel_color #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  hgpc_pkg::req_t                  req,
	output logic                            done,
	output hgpc_pkg::rsp_t                  rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [hgpc_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [hgpc_pkg::DATA_BITS-1:0]  pwdata,
	output logic [hgpc_pkg::DATA_BITS-1:0]  prdata,
	output logic                            pready
);
	import hgpc_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int F     = FRAC_BITS;
	localparam int DEPTH = C + F;
	localparam int LAT   = C + F + 4;
	localparam int PW    = 2 * F + 1;
	localparam int CW    = 2 * C + 2;
	localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

	typedef struct packed {
		logic [C-1:0] dv;
		logic [C-1:0] sat_num;
		logic [C-1:0] br_num;
		sel_t         sat_mode;
		sel_t         br_mode;
	} side_t;

	// channel byte: (v * 255) >> F
	function automatic logic [7:0] to_byte(input logic [F:0] v);
		logic [F+8:0] m;
		m = {v, 8'b0} - {8'b0, v};
		return m[F+7:F];
	endfunction

	// configuration registers
	logic [REG_BITS-1:0] aw_q, ah_q;
	logic                wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q <= REG_BITS'(256);
			ah_q <= REG_BITS'(256);
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_AREA_WIDTH:  aw_q <= pwdata[REG_BITS-1:0];
				REG_AREA_HEIGHT: ah_q <= pwdata[REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_AREA_WIDTH:  prdata = {{(DATA_BITS-REG_BITS){1'b0}}, aw_q};
			REG_AREA_HEIGHT: prdata = {{(DATA_BITS-REG_BITS){1'b0}}, ah_q};
			default:         prdata = '0;
		endcase
	end

	assign busy = 1'b0;

	// region decode at the input
	logic [C-1:0] half;
	logic [C:0]   two_half;
	logic [C:0]   br_diff;
	side_t        prep;

	always_comb begin
		half     = ah_q[C:1];
		two_half = {half, 1'b0};
		br_diff  = two_half - {1'b0, req.pos_y};
		prep     = '0;
		if (req.pos_y <= half) begin
			prep.dv      = half;
			prep.sat_num = req.pos_y;
			prep.br_mode = SEL_ONE;
			if (half == '0)
				prep.sat_mode = SEL_ZERO;
			else if (req.pos_y == half)
				prep.sat_mode = SEL_ONE;
			else
				prep.sat_mode = SEL_DIV;
		end else begin
			prep.dv       = req.pos_y;
			prep.sat_num  = half;
			prep.sat_mode = SEL_DIV;
			if ({1'b0, req.pos_y} > two_half) begin
				prep.br_mode = SEL_ZERO;
			end else begin
				prep.br_mode = SEL_DIV;
				prep.br_num  = br_diff[C-1:0];
			end
		end
	end

	// input capture and valid / side shift line
	logic [C-1:0] x_s1;
	side_t        side_q [0:DEPTH];
	logic         vld_q  [0:DEPTH];

	always_ff @(posedge clk) begin
		x_s1      <= req.pos_x;
		side_q[0] <= prep;
		for (int k = 1; k <= DEPTH; k++)
			side_q[k] <= side_q[k-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DEPTH; k++)
				vld_q[k] <= 1'b0;
		end else begin
			vld_q[0] <= start && !busy;
			for (int k = 1; k <= DEPTH; k++)
				vld_q[k] <= vld_q[k-1];
		end
	end

	// modulo chain: x mod width
	logic [C:0]   md_rem [0:C];
	logic [C-1:0] md_quo [0:C];

	assign md_rem[0] = '0;
	assign md_quo[0] = x_s1;

	for (genvar k = 0; k < C; k++) begin : g_mod
		hgpc_div_cell #(.RW(C + 1), .QW(C)) u_cell (
			.clk     (clk),
			.divisor (aw_q),
			.rem_in  (md_rem[k]),
			.quo_in  (md_quo[k]),
			.rem_out (md_rem[k+1]),
			.quo_out (md_quo[k+1])
		);
	end

	// divide chain: hue, saturation and brightness lanes
	logic [C:0]   hu_rem [0:F];
	logic [F-1:0] hu_quo [0:F];
	logic [C-1:0] sa_rem [0:F];
	logic [F-1:0] sa_quo [0:F];
	logic [C-1:0] br_rem [0:F];
	logic [F-1:0] br_quo [0:F];

	assign hu_rem[0] = md_rem[C];
	assign hu_quo[0] = '0;
	assign sa_rem[0] = side_q[C].sat_num;
	assign sa_quo[0] = '0;
	assign br_rem[0] = side_q[C].br_num;
	assign br_quo[0] = '0;

	for (genvar j = 0; j < F; j++) begin : g_div
		hgpc_div_cell #(.RW(C + 1), .QW(F)) u_hue (
			.clk     (clk),
			.divisor (aw_q),
			.rem_in  (hu_rem[j]),
			.quo_in  (hu_quo[j]),
			.rem_out (hu_rem[j+1]),
			.quo_out (hu_quo[j+1])
		);
		hgpc_div_cell #(.RW(C), .QW(F)) u_sat (
			.clk     (clk),
			.divisor (side_q[C+j].dv),
			.rem_in  (sa_rem[j]),
			.quo_in  (sa_quo[j]),
			.rem_out (sa_rem[j+1]),
			.quo_out (sa_quo[j+1])
		);
		hgpc_div_cell #(.RW(C), .QW(F)) u_bri (
			.clk     (clk),
			.divisor (side_q[C+j].dv),
			.rem_in  (br_rem[j]),
			.quo_in  (br_quo[j]),
			.rem_out (br_rem[j+1]),
			.quo_out (br_quo[j+1])
		);
	end

	// stage 2: sector, f and saturation products
	logic [F-1:0] hue;
	logic [F+2:0] hsix;
	logic [F-1:0] frac;
	logic [F:0]   sat, bri, omf;
	logic [PW-1:0] p_sf, p_sg;

	always_comb begin
		hue  = (aw_q == '0) ? '0 : hu_quo[F];
		hsix = ({3'b0, hue} << 2) + ({3'b0, hue} << 1);
		frac = hsix[F-1:0];
		omf  = ONE - {1'b0, frac};
		case (side_q[DEPTH].sat_mode)
			SEL_DIV: sat = {1'b0, sa_quo[F]};
			SEL_ONE: sat = ONE;
			default: sat = '0;
		endcase
		case (side_q[DEPTH].br_mode)
			SEL_DIV: bri = {1'b0, br_quo[F]};
			SEL_ONE: bri = ONE;
			default: bri = '0;
		endcase
		p_sf = PW'(sat) * PW'(frac);
		p_sg = PW'(sat) * PW'(omf);
	end

	logic [2:0] sec_s2;
	logic [F:0] sf_s2, sg_s2, oms_s2, bri_s2;
	logic       vld_s2;

	always_ff @(posedge clk) begin
		sec_s2 <= hsix[F+2:F];
		sf_s2  <= p_sf[2*F:F];
		sg_s2  <= p_sg[2*F:F];
		oms_s2 <= ONE - sat;
		bri_s2 <= bri;
	end

	// stage 3: p, q and t
	logic [PW-1:0] p_p, p_q, p_t;

	always_comb begin
		p_p = PW'(bri_s2) * PW'(oms_s2);
		p_q = PW'(bri_s2) * PW'(ONE - sf_s2);
		p_t = PW'(bri_s2) * PW'(ONE - sg_s2);
	end

	logic [2:0] sec_s3;
	logic [F:0] p_s3, q_s3, t_s3, bri_s3;
	logic       vld_s3;

	always_ff @(posedge clk) begin
		sec_s3 <= sec_s2;
		p_s3   <= p_p[2*F:F];
		q_s3   <= p_q[2*F:F];
		t_s3   <= p_t[2*F:F];
		bri_s3 <= bri_s2;
	end

	// stage 4: sector select and byte conversion
	logic [F:0] r_v, g_v, b_v;

	always_comb begin
		case (sec_s3)
			3'd0:    begin r_v = bri_s3; g_v = t_s3;   b_v = p_s3;   end
			3'd1:    begin r_v = q_s3;   g_v = bri_s3; b_v = p_s3;   end
			3'd2:    begin r_v = p_s3;   g_v = bri_s3; b_v = t_s3;   end
			3'd3:    begin r_v = p_s3;   g_v = q_s3;   b_v = bri_s3; end
			3'd4:    begin r_v = t_s3;   g_v = p_s3;   b_v = bri_s3; end
			default: begin r_v = bri_s3; g_v = p_s3;   b_v = q_s3;   end
		endcase
	end

	rsp_t rsp_s4;
	logic vld_s4;

	always_ff @(posedge clk) begin
		rsp_s4.red   <= to_byte(r_v);
		rsp_s4.green <= to_byte(g_v);
		rsp_s4.blue  <= to_byte(b_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= vld_q[DEPTH];
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign done = vld_s4;
	assign rsp  = rsp_s4;

	// checks
	logic          md_on;
	logic [CW-1:0] md_chk;

	assign md_on  = vld_q[C] && (aw_q != '0);
	assign md_chk = CW'(md_quo[C]) * CW'(aw_q) + CW'(md_rem[C]);

	`HGPC_ASSERT_NOW(a_latency, start && !busy, ##LAT done, "request gave no result on time")
	`HGPC_ASSERT_NOW(a_no_ghost, done, $past(start && !busy, LAT), "result without request")
	`HGPC_ASSERT_NOW(a_mod_rem, md_on, md_rem[C] < aw_q, "remainder not below width")
	`HGPC_ASSERT_NOW(a_mod_sum, md_on, md_chk == CW'($past(x_s1, C)), "modulo chain mismatch")

endmodule
